@@ design/plant_startup_shutdown_sequencer_top_assert.svh @@
// Assertion macros for the plant startup and shutdown sequencer
`ifndef PLANT_STARTUP_SHUTDOWN_SEQUENCER_TOP_ASSERT_SVH
`define PLANT_STARTUP_SHUTDOWN_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PSSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define PSSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/psss_pkg.sv @@
// Types, constants and helpers of the plant startup and shutdown sequencer
`default_nettype none

package psss_pkg;

	localparam int TIME_BITS = 32;
	localparam logic [TIME_BITS-1:0] SEND_INTERVAL_MS = TIME_BITS'(500);

	localparam logic [7:0] DUTY_0   = 8'd0;
	localparam logic [7:0] DUTY_40  = 8'd102;
	localparam logic [7:0] DUTY_50  = 8'd127;
	localparam logic [7:0] DUTY_60  = 8'd153;
	localparam logic [7:0] DUTY_100 = 8'd255;

	localparam logic [4:0] RELAY_STEAM1     = 5'b00001;
	localparam logic [4:0] RELAY_CONDENSER  = 5'b00100;
	localparam logic [4:0] RELAY_TOWER1     = 5'b01000;
	localparam logic [4:0] RELAY_LVL_NORMAL = 5'b01101;
	localparam logic [4:0] RELAY_ALL        = 5'b11111;

	localparam logic [1:0] LVL_OFF    = 2'd0;
	localparam logic [1:0] LVL_NORMAL = 2'd1;
	localparam logic [1:0] LVL_MAX    = 2'd2;

	localparam logic [2:0] STAGE_1 = 3'd1;
	localparam logic [2:0] STAGE_2 = 3'd2;
	localparam logic [2:0] STAGE_3 = 3'd3;
	localparam logic [2:0] STAGE_4 = 3'd4;

	localparam logic [2:0] CFG_ROD_A_LOW   = 3'd0;
	localparam logic [2:0] CFG_ROD_B_LOW   = 3'd1;
	localparam logic [2:0] CFG_ROD_A_HIGH  = 3'd2;
	localparam logic [2:0] CFG_ROD_B_HIGH  = 3'd3;
	localparam logic [2:0] CFG_ROD_A_ALARM = 3'd4;
	localparam logic [2:0] CFG_ROD_B_ALARM = 3'd5;
	localparam logic [2:0] CFG_STAGE_DELAY = 3'd6;
	localparam logic [2:0] CFG_BLINK_HALF  = 3'd7;

	localparam logic [1:0] PHASE_CODE_IDLE  = 2'd0;
	localparam logic [1:0] PHASE_CODE_START = 2'd1;
	localparam logic [1:0] PHASE_CODE_RUN   = 2'd2;
	localparam logic [1:0] PHASE_CODE_STOP  = 2'd3;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_START = 4'b0010,
		PH_RUN   = 4'b0100,
		PH_STOP  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [4:0] relay;
		logic [7:0] steam;
		logic [7:0] turbine;
		logic [7:0] pump;
		logic [7:0] tower;
	} drive_t;

	function automatic logic [1:0] phase_code(input phase_t ph);
		logic [1:0] code;
		case (ph)
			PH_IDLE:  code = PHASE_CODE_IDLE;
			PH_START: code = PHASE_CODE_START;
			PH_RUN:   code = PHASE_CODE_RUN;
			PH_STOP:  code = PHASE_CODE_STOP;
			default:  code = PHASE_CODE_IDLE;
		endcase
		return code;
	endfunction

	function automatic drive_t level_drive(input logic [1:0] lvl);
		drive_t d;
		if (lvl == LVL_MAX) begin
			d.relay   = RELAY_ALL;
			d.steam   = DUTY_100;
			d.turbine = DUTY_100;
			d.pump    = DUTY_100;
			d.tower   = DUTY_100;
		end else begin
			d.relay   = RELAY_LVL_NORMAL;
			d.steam   = DUTY_50;
			d.turbine = DUTY_40;
			d.pump    = DUTY_60;
			d.tower   = DUTY_60;
		end
		return d;
	endfunction

endpackage

`default_nettype wire

@@ design/plant_startup_shutdown_sequencer_top.sv @@
// Top level of the plant startup and shutdown sequencer
`default_nettype none

// Takes one beat per cycle unless stalled: a beat lands in an input register, the sequencer
// state and the result are worked out from it combinationally and the result beat is held in
// the result register. Throughput is one beat per clock unless stalled, set by the single state
// update from the input register to the result register; the input side stalls only while a
// result is stalled and the input register is full. Configuration writes take effect at the
// next edge and are meant for times when no beat is in flight.
module plant_startup_shutdown_sequencer_top import psss_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [6:0]  rod_a_position,
	input  wire logic [6:0]  rod_b_position,
	input  wire logic [31:0] now_ms,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [4:0]       relay_bits,
	output logic [7:0]       steam_fan_duty,
	output logic [7:0]       turbine_duty,
	output logic [7:0]       condenser_pump_duty,
	output logic [7:0]       tower_fan_duty,
	output logic             buzzer_on,
	output logic [1:0]       level_now,
	output logic [1:0]       phase_now,
	output logic             send_level_pulse
);

	logic [6:0]  rod_a_low_q, rod_b_low_q, rod_a_high_q, rod_b_high_q;
	logic [6:0]  rod_a_alarm_q, rod_b_alarm_q;
	logic [15:0] stage_delay_q, blink_half_q;

	logic        valid_s1;
	logic [6:0]  rod_a_s1, rod_b_s1;
	logic [31:0] now_s1;

	phase_t               phase_q;
	logic [2:0]           stage_q;
	logic [TIME_BITS-1:0] stage_start_q, blink_start_q, last_send_q;
	logic [1:0]           prior_level_q;
	logic                 buzzer_q;
	drive_t               drive_q;

	logic       out_valid_q;
	drive_t     res_drive_q;
	logic       res_buzzer_q;
	logic [1:0] res_level_q;
	logic [1:0] res_phase_q;
	logic       res_pulse_q;

	logic                 adv;
	logic [TIME_BITS-1:0] now_t, el_stage, el_blink, el_send;
	logic [1:0]           lvl;
	logic                 stage_due;
	phase_t               n_phase;
	logic [2:0]           n_stage;
	logic [TIME_BITS-1:0] n_stage_start, n_blink_start, n_last_send;
	logic                 n_buzzer;
	drive_t               n_drive;
	logic                 pulse;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rod_a_low_q   <= 7'd21;
			rod_b_low_q   <= 7'd16;
			rod_a_high_q  <= 7'd41;
			rod_b_high_q  <= 7'd31;
			rod_a_alarm_q <= 7'd70;
			rod_b_alarm_q <= 7'd55;
			stage_delay_q <= 16'd5000;
			blink_half_q  <= 16'd500;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_ROD_A_LOW:   rod_a_low_q   <= cfg_data[6:0];
				CFG_ROD_B_LOW:   rod_b_low_q   <= cfg_data[6:0];
				CFG_ROD_A_HIGH:  rod_a_high_q  <= cfg_data[6:0];
				CFG_ROD_B_HIGH:  rod_b_high_q  <= cfg_data[6:0];
				CFG_ROD_A_ALARM: rod_a_alarm_q <= cfg_data[6:0];
				CFG_ROD_B_ALARM: rod_b_alarm_q <= cfg_data[6:0];
				CFG_STAGE_DELAY: stage_delay_q <= cfg_data;
				CFG_BLINK_HALF:  blink_half_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rod_a_s1 <= rod_a_position;
			rod_b_s1 <= rod_b_position;
			now_s1   <= now_ms;
		end
	end

	assign now_t    = TIME_BITS'(now_s1);
	assign el_stage = now_t - stage_start_q;
	assign el_blink = now_t - blink_start_q;
	assign el_send  = now_t - last_send_q;
	assign stage_due = el_stage > TIME_BITS'(stage_delay_q);
	assign pulse     = el_send > SEND_INTERVAL_MS;

	always_comb begin
		if (rod_a_s1 < rod_a_low_q || rod_b_s1 < rod_b_low_q) begin
			lvl = LVL_OFF;
		end else if (rod_a_s1 >= rod_a_high_q && rod_b_s1 >= rod_b_high_q) begin
			lvl = LVL_MAX;
		end else begin
			lvl = LVL_NORMAL;
		end
	end

	always_comb begin
		n_phase       = phase_q;
		n_stage       = stage_q;
		n_stage_start = stage_start_q;
		n_blink_start = blink_start_q;
		n_last_send   = pulse ? now_t : last_send_q;
		n_buzzer      = buzzer_q;
		n_drive       = drive_q;
		case (phase_q)
			PH_IDLE: begin
				if (lvl != LVL_OFF) begin
					n_phase       = PH_START;
					n_stage       = STAGE_1;
					n_stage_start = now_t;
					n_drive.relay = drive_q.relay | RELAY_STEAM1;
					n_drive.steam = DUTY_50;
				end
			end
			PH_START: begin
				if (lvl == LVL_OFF) begin
					n_phase       = PH_STOP;
					n_stage       = STAGE_1;
					n_stage_start = now_t;
					n_drive       = '0;
					n_buzzer      = 1'b0;
				end else if (stage_due) begin
					n_stage       = stage_q + 3'd1;
					n_stage_start = now_t;
					case (n_stage)
						STAGE_1: begin
							n_drive.relay = drive_q.relay | RELAY_STEAM1;
							n_drive.steam = DUTY_50;
						end
						STAGE_2: n_drive.turbine = DUTY_40;
						STAGE_3: begin
							n_drive.relay = drive_q.relay | RELAY_CONDENSER;
							n_drive.pump  = DUTY_60;
						end
						STAGE_4: begin
							n_phase = PH_RUN;
							n_drive = level_drive(lvl);
						end
						default: ;
					endcase
				end
			end
			PH_RUN: begin
				if (lvl == LVL_OFF) begin
					n_phase       = PH_STOP;
					n_stage       = STAGE_1;
					n_stage_start = now_t;
					n_drive       = '0;
					n_buzzer      = 1'b0;
				end else begin
					if (lvl != prior_level_q) begin
						n_drive = level_drive(lvl);
					end
					if (lvl == LVL_MAX && rod_a_s1 >= rod_a_alarm_q
							&& rod_b_s1 >= rod_b_alarm_q) begin
						if (el_blink > TIME_BITS'(blink_half_q)) begin
							n_blink_start = now_t;
							n_buzzer      = !buzzer_q;
						end
					end else begin
						n_buzzer = 1'b0;
					end
				end
			end
			PH_STOP: begin
				if (stage_due) begin
					n_stage       = stage_q + 3'd1;
					n_stage_start = now_t;
					case (n_stage)
						STAGE_2: n_drive.turbine = DUTY_0;
						STAGE_3: n_drive.pump    = DUTY_0;
						STAGE_4: begin
							n_drive.tower = DUTY_0;
							n_phase       = PH_IDLE;
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			stage_q       <= '0;
			stage_start_q <= '0;
			blink_start_q <= '0;
			last_send_q   <= '0;
			prior_level_q <= LVL_OFF;
			buzzer_q      <= 1'b0;
			drive_q       <= '0;
		end else if (adv) begin
			phase_q       <= n_phase;
			stage_q       <= n_stage;
			stage_start_q <= n_stage_start;
			blink_start_q <= n_blink_start;
			last_send_q   <= n_last_send;
			prior_level_q <= lvl;
			buzzer_q      <= n_buzzer;
			drive_q       <= n_drive;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_drive_q  <= n_drive;
			res_buzzer_q <= n_buzzer;
			res_level_q  <= lvl;
			res_phase_q  <= phase_code(n_phase);
			res_pulse_q  <= pulse;
		end
	end

	assign out_valid           = out_valid_q;
	assign relay_bits          = res_drive_q.relay;
	assign steam_fan_duty      = res_drive_q.steam;
	assign turbine_duty        = res_drive_q.turbine;
	assign condenser_pump_duty = res_drive_q.pump;
	assign tower_fan_duty      = res_drive_q.tower;
	assign buzzer_on           = res_buzzer_q;
	assign level_now           = res_level_q;
	assign phase_now           = res_phase_q;
	assign send_level_pulse    = res_pulse_q;

`include "plant_startup_shutdown_sequencer_top_assert.svh"

	`PSSS_ASSERT_NEXT(a_adv_gives_beat, adv, out_valid_q, "advanced beat did not reach result")
	`PSSS_ASSERT_NOW(a_run_relays, phase_q == PH_RUN, drive_q.relay == RELAY_LVL_NORMAL || drive_q.relay == RELAY_ALL, "running with relays off level pattern")
	`PSSS_ASSERT_NOW(a_buzzer_run_only, buzzer_q, phase_q == PH_RUN, "buzzer on outside running")
	`PSSS_ASSERT_NOW(a_stage_range, phase_q != PH_IDLE, stage_q >= STAGE_1 && stage_q <= STAGE_4, "stage out of range while sequencing")

endmodule

`default_nettype wire
